// ===== hdl/ecp_pkg.sv =====
// Shared constants and types for the conservative-to-primitive conversion unit.
package ecp_pkg;

    localparam int DataW = 32;
    localparam int FracW = 16;
    localparam int DivW = DataW + FracW;
    localparam int GammaW = 17;

    localparam logic [1:0] EqCopy = 2'd0;
    localparam logic [1:0] Eq1d = 2'd1;
    localparam logic [1:0] Eq2d = 2'd2;

    localparam logic [1:0] RegEqMode = 2'd0;
    localparam logic [1:0] RegGamma = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [1:0]       mode;
        logic             bad;
        logic             last;
        logic             sign_x;
        logic             sign_y;
        logic [DataW-1:0] dens;
        logic [DataW-1:0] mom_x;
        logic [DataW-1:0] mom_y;
        logic [DataW-1:0] energy;
    } t_side;

endpackage

// ===== hdl/ecp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ecp_div
    import ecp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DivW-1:0]  i_num,
    input  logic [DataW-1:0] i_den,
    output logic [DivW-1:0]  o_quo
);

    logic [DataW-1:0] r_rem [DivW];
    logic [DivW-1:0]  r_num [DivW];
    logic [DataW-1:0] r_den [DivW];
    logic [DataW-1:0] n_rem [DivW];
    logic [DivW-1:0]  n_num [DivW];

    always_comb begin
        for (int k = 0; k < DivW; k++) begin
            logic [DataW:0]   tmp;
            logic [DataW-1:0] rem_in;
            logic [DivW-1:0]  num_in;
            logic [DataW-1:0] den_in;
            logic             ge;
            rem_in = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k - 1];
            num_in = (k == 0) ? i_num : r_num[(k == 0) ? 0 : k - 1];
            den_in = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            tmp = {rem_in, num_in[DivW-1]};
            ge = tmp >= {1'b0, den_in};
            n_rem[k] = ge ? DataW'(tmp - {1'b0, den_in}) : tmp[DataW-1:0];
            n_num[k] = {num_in[DivW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DivW; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_quo = r_num[DivW-1];

endmodule

// ===== hdl/euler_cons_to_prim_unit.sv =====
// Top level of the conservative-to-primitive conversion unit.
// Accepts one cell per cycle unless the pipeline is held; each cell passes from input transfer to output valid
// through the capture stage, the 48-stage bit-per-stage velocity dividers, then saturate,
// kinetic multiply, energy subtract, gamma multiply and output stages. The whole pipeline
// holds when the output register is full and not taken. Configuration writes are always ready.
module euler_cons_to_prim_unit
    import ecp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DataW-1:0]  i_density,
    input  logic [DataW-1:0]  i_x_momentum,
    input  logic [DataW-1:0]  i_y_momentum,
    input  logic [DataW-1:0]  i_total_energy,
    input  logic              i_last_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DataW-1:0]  o_density_out,
    output logic [DataW-1:0]  o_velocity_x,
    output logic [DataW-1:0]  o_velocity_y,
    output logic [DataW-1:0]  o_pressure,
    output logic              o_bad_density,
    output logic              o_last_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [GammaW-1:0] i_cfg_data
);

    logic              en;
    logic [1:0]        r_eq_mode;
    logic [GammaW-1:0] r_gamma;

    t_side             r_a;
    logic [DivW-1:0]   r_a_num_x;
    logic [DivW-1:0]   r_a_num_y;
    t_side             r_side [DivW];
    logic [DivW-1:0]   quo_x;
    logic [DivW-1:0]   quo_y;

    t_side             r_b;
    logic [DataW-1:0]  r_b_u;
    logic [DataW-1:0]  r_b_v;
    t_side             r_c;
    logic [DataW-1:0]  r_c_u;
    logic [DataW-1:0]  r_c_v;
    logic [63:0]       r_c_kx;
    logic [63:0]       r_c_ky;
    t_side             r_d;
    logic [DataW-1:0]  r_d_u;
    logic [DataW-1:0]  r_d_v;
    logic              r_d_neg;
    logic [DivW-1:0]   r_d_mag;
    t_side             r_e;
    logic [DataW-1:0]  r_e_u;
    logic [DataW-1:0]  r_e_v;
    logic              r_e_neg;
    logic [64:0]       r_e_prod;

    logic              r_out_valid;

    assign en = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eq_mode <= Eq1d;
            r_gamma <= GammaW'(26214);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegEqMode: r_eq_mode <= i_cfg_data[1:0];
                RegGamma:  r_gamma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: capture and take magnitudes
    logic [DataW-1:0] abs_x;
    logic [DataW-1:0] abs_y;
    logic             in_bad;
    assign abs_x = i_x_momentum[DataW-1] ? DataW'(-i_x_momentum) : i_x_momentum;
    assign abs_y = (r_eq_mode == Eq2d) ?
                   (i_y_momentum[DataW-1] ? DataW'(-i_y_momentum) : i_y_momentum) : '0;
    assign in_bad = (r_eq_mode == Eq1d || r_eq_mode == Eq2d) &&
                    ($signed(i_density) <= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (en) begin
            r_a.valid <= i_in_valid;
            r_a.mode <= r_eq_mode;
            r_a.bad <= in_bad;
            r_a.last <= i_last_in;
            r_a.sign_x <= i_x_momentum[DataW-1];
            r_a.sign_y <= i_y_momentum[DataW-1];
            r_a.dens <= i_density;
            r_a.mom_x <= i_x_momentum;
            r_a.mom_y <= (r_eq_mode == Eq1d) ? '0 : i_y_momentum;
            r_a.energy <= i_total_energy;
            r_a_num_x <= {abs_x, FracW'(0)};
            r_a_num_y <= {abs_y, FracW'(0)};
        end
    end

    ecp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_num_x),
        .i_den (r_a.dens),
        .o_quo (quo_x)
    );

    ecp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_num_y),
        .i_den (r_a.dens),
        .o_quo (quo_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivW; k++) r_side[k].valid <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < DivW; k++)
                r_side[k] <= (k == 0) ? r_a : r_side[(k == 0) ? 0 : k - 1];
        end
    end

    // stage B: apply sign and saturate velocities
    function automatic logic [DataW-1:0] sat_quo(input logic [DivW-1:0] q, input logic neg);
        logic [DataW-1:0] res;
        if (!neg) begin
            res = (q > DivW'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[DataW-1:0];
        end else begin
            res = (q > DivW'(32'h8000_0000)) ? 32'h8000_0000 : DataW'(-q[DataW-1:0]);
        end
        return res;
    endfunction

    t_side last_side;
    assign last_side = r_side[DivW-1];

    // stage D helpers: kinetic half and energy difference
    logic [63:0]      kin;
    logic [46:0]      half;
    logic [DivW:0]    diff;
    assign kin = r_c_kx + r_c_ky;
    assign half = kin[63:17];
    assign diff = {{(DivW+1-DataW){r_c.energy[DataW-1]}}, r_c.energy} - {2'b00, half};

    // output stage helpers
    logic [64:0]      rnd;
    logic [48:0]      qpos;
    logic [48:0]      qneg;
    logic [DataW-1:0] p_sat;
    assign rnd = r_e_prod + 65'd65535;
    assign qpos = r_e_prod[64:16];
    assign qneg = rnd[64:16];
    assign p_sat = !r_e_neg ?
                   ((qpos > 49'h7fff_ffff) ? 32'h7fff_ffff : qpos[DataW-1:0]) :
                   ((qneg > 49'h8000_0000) ? 32'h8000_0000 : DataW'(-qneg[DataW-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_e.valid;

            r_b <= last_side;
            r_b_u <= sat_quo(quo_x, last_side.sign_x);
            r_b_v <= (last_side.mode == Eq2d) ? sat_quo(quo_y, last_side.sign_y) : '0;

            r_c <= r_b;
            r_c_u <= r_b_u;
            r_c_v <= r_b_v;
            r_c_kx <= 64'($signed(r_b.mom_x) * $signed(r_b_u));
            r_c_ky <= 64'($signed(r_b.mom_y) * $signed(r_b_v));

            r_d <= r_c;
            r_d_u <= r_c_u;
            r_d_v <= r_c_v;
            r_d_neg <= diff[DivW];
            r_d_mag <= diff[DivW] ? DivW'(-diff) : diff[DivW-1:0];

            r_e <= r_d;
            r_e_u <= r_d_u;
            r_e_v <= r_d_v;
            r_e_neg <= r_d_neg;
            r_e_prod <= 65'(r_d_mag * r_gamma);

            o_last_out <= r_e.last;
            case (r_e.mode)
                EqCopy: begin
                    o_density_out <= r_e.dens;
                    o_velocity_x <= r_e.mom_x;
                    o_velocity_y <= r_e.mom_y;
                    o_pressure <= r_e.energy;
                    o_bad_density <= 1'b0;
                end
                Eq1d, Eq2d: begin
                    o_density_out <= r_e.dens;
                    o_velocity_x <= r_e.bad ? '0 : r_e_u;
                    o_velocity_y <= r_e.bad ? '0 : r_e_v;
                    o_pressure <= r_e.bad ? '0 : p_sat;
                    o_bad_density <= r_e.bad;
                end
                default: begin
                    o_density_out <= '0;
                    o_velocity_x <= '0;
                    o_velocity_y <= '0;
                    o_pressure <= '0;
                    o_bad_density <= 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_bad_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_density |->
            o_velocity_x == '0 && o_velocity_y == '0 && o_pressure == '0)
        else $error("bad density result carries nonzero values");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked output");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
